>>> rtl/binary_heap_priority_queue_top_assert.svh
// Assertion macros shared by the priority queue RTL.
// They expect clk and arst_n in the scope where they are used.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BHPQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BHPQ_ASSERT_NEXT(label, ante, cons, msg) \
	`BHPQ_ASSERT(label, (ante) |=> (cons), msg)
`else
`define BHPQ_ASSERT(label, prop, msg)
`define BHPQ_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> rtl/bhpq_pkg.sv
package bhpq_pkg;

	localparam int CAPACITY   = 1024;
	localparam int KEY_BITS   = 32;
	localparam int COUNT_BITS = $clog2(CAPACITY + 1);

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		op_t                 op;
		logic [KEY_BITS-1:0] key;
	} bhpq_in_t;

	typedef struct packed {
		status_t               status;
		logic [KEY_BITS-1:0]   popped_key;
		logic [KEY_BITS-1:0]   top_key;
		logic                  top_valid;
		logic [COUNT_BITS-1:0] count;
	} bhpq_out_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_DN_LAST,
		S_DN_RDL,
		S_DN_RDR,
		S_DN_SEL,
		S_DN_CMP,
		S_FIN
	} state_t;

endpackage

>>> rtl/binary_heap_priority_queue_top.sv
// Push: the new key rises d levels, with a parent read (S_UP_RD) and compare (S_UP_CMP) per level.
// Pop: the last key moves to the root and sinks d levels; no right child skips S_DN_SEL.
// Rejected operations and a pop of the last entry go straight to S_FIN; d <= log2(CAPACITY).
// One item at a time: the next transfer is taken in the cycle after the result is loaded,
// and a stalled waiting result delays that load. The one-read, one-write memory sets the pace.
// Reset clears the count and order bit at once; the heap is empty with no clearing pass.
`include "binary_heap_priority_queue_top_assert.svh"

module binary_heap_priority_queue_top
	import bhpq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  bhpq_in_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output bhpq_out_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = AW + 2;

	state_t state_q, state_d;

	logic [CW-1:0]       cnt_q;
	logic                min_first_q;
	logic [AW-1:0]       pos_q;
	logic [AW-1:0]       pick_q;
	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] lkey_q;
	logic [KEY_BITS-1:0] root_q;
	logic [KEY_BITS-1:0] rdata_q;
	status_t             status_q;
	logic [KEY_BITS-1:0] popped_q;
	logic                out_valid_q;
	bhpq_out_t           out_q;

	logic [KEY_BITS-1:0] mem_q [CAPACITY];

	logic                in_fire;
	logic                out_load;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [KEY_BITS-1:0] mem_wdata;
	logic [AW-1:0]       mem_raddr;
	logic [KEY_BITS-1:0] cmp_a;
	logic [KEY_BITS-1:0] cmp_b;
	logic                cmp_above;
	logic [AW-1:0]       parent_pos;
	logic [XW-1:0]       left_pos;
	logic [XW-1:0]       right_pos;
	logic [XW-1:0]       cnt_x;
	logic                is_full;
	logic                is_empty;

	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_load  = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	assign is_full    = (cnt_q == CW'(CAPACITY));
	assign is_empty   = (cnt_q == '0);
	assign parent_pos = (pos_q - AW'(1)) >> 1;
	assign left_pos   = {1'b0, pos_q, 1'b1};
	assign right_pos  = left_pos + XW'(1);
	assign cnt_x      = XW'(cnt_q);

	bhpq_cmp #(
		.KEY_WIDTH(KEY_BITS)
	) u_cmp (
		.a        (cmp_a),
		.b        (cmp_b),
		.min_first(min_first_q),
		.above    (cmp_above)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = key_q;
		mem_raddr = AW'(cnt_q - CW'(1));
		cmp_a     = key_q;
		cmp_b     = rdata_q;
		unique case (state_q)
			S_IDLE: begin
				// The read of the last entry is issued here so a pop can use it next cycle.
				if (in_fire) begin
					if (in_data.op == OP_PUSH) begin
						state_d = is_full ? S_FIN : S_UP_RD;
					end else if (is_empty || cnt_q == CW'(1)) begin
						state_d = S_FIN;
					end else begin
						state_d = S_DN_LAST;
					end
				end
			end
			S_UP_RD: begin
				if (pos_q == '0) begin
					mem_we  = 1'b1;
					state_d = S_FIN;
				end else begin
					mem_raddr = parent_pos;
					state_d   = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				mem_we = 1'b1;
				if (cmp_above) begin
					mem_wdata = rdata_q;
					state_d   = S_UP_RD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_DN_LAST: begin
				state_d = S_DN_RDL;
			end
			S_DN_RDL: begin
				if (left_pos >= cnt_x) begin
					mem_we  = 1'b1;
					state_d = S_FIN;
				end else begin
					mem_raddr = left_pos[AW-1:0];
					state_d   = S_DN_RDR;
				end
			end
			S_DN_RDR: begin
				mem_raddr = right_pos[AW-1:0];
				state_d   = (right_pos < cnt_x) ? S_DN_SEL : S_DN_CMP;
			end
			S_DN_SEL: begin
				cmp_a   = rdata_q;
				cmp_b   = lkey_q;
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				cmp_a  = lkey_q;
				cmp_b  = key_q;
				mem_we = 1'b1;
				if (cmp_above) begin
					mem_wdata = lkey_q;
					state_d   = S_DN_RDL;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			min_first_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				min_first_q <= cfg_wdata;
			end
			if (in_fire) begin
				if (in_data.op == OP_PUSH && !is_full) begin
					cnt_q <= cnt_q + CW'(1);
				end else if (in_data.op == OP_POP && !is_empty) begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_q <= in_data.key;
			pos_q <= AW'(cnt_q);
			if (in_data.op == OP_PUSH) begin
				status_q <= is_full ? STAT_FULL : STAT_OK;
				popped_q <= '0;
			end else if (is_empty) begin
				status_q <= STAT_EMPTY;
				popped_q <= '0;
			end else begin
				status_q <= STAT_OK;
				popped_q <= root_q;
			end
		end
		unique case (state_q)
			S_UP_CMP: begin
				if (cmp_above) begin
					pos_q <= parent_pos;
				end
			end
			S_DN_LAST: begin
				key_q <= rdata_q;
				pos_q <= '0;
			end
			S_DN_RDR: begin
				lkey_q <= rdata_q;
				pick_q <= left_pos[AW-1:0];
			end
			S_DN_SEL: begin
				if (cmp_above) begin
					lkey_q <= rdata_q;
					pick_q <= right_pos[AW-1:0];
				end
			end
			S_DN_CMP: begin
				if (cmp_above) begin
					pos_q <= pick_q;
				end
			end
			default: begin
			end
		endcase
		// Keep a copy of the root so the result and the next pop need no memory read.
		if (mem_we && mem_waddr == '0) begin
			root_q <= mem_wdata;
		end
		if (out_load) begin
			out_q.status     <= status_q;
			out_q.popped_key <= popped_q;
			out_q.top_key    <= is_empty ? '0 : root_q;
			out_q.top_valid  <= !is_empty;
			out_q.count      <= COUNT_BITS'(cnt_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem_q[mem_raddr];
	end

	`BHPQ_ASSERT(a_write_in_range, mem_we |-> (CW'(mem_waddr) < cnt_q), "heap write beyond count")
	`BHPQ_ASSERT(a_count_bound, cnt_q <= CW'(CAPACITY), "entry count above capacity")
	`BHPQ_ASSERT_NEXT(a_full_push, in_fire && in_data.op == OP_PUSH && is_full, cnt_q == $past(cnt_q) && status_q == STAT_FULL, "push on full heap changed count")
	`BHPQ_ASSERT_NEXT(a_pop_count, in_fire && in_data.op == OP_POP && !is_empty, cnt_q == $past(cnt_q) - CW'(1), "pop did not lower count")
	`BHPQ_ASSERT(a_result_from_fin, $rose(out_valid_q) |-> $past(state_q == S_FIN), "result raised outside final state")

endmodule

>>> rtl/bhpq_cmp.sv
// Shared key comparator: above is high when key a must sit closer to the root than key b.
module bhpq_cmp #(
	parameter int KEY_WIDTH = 32
) (
	input  logic [KEY_WIDTH-1:0] a,
	input  logic [KEY_WIDTH-1:0] b,
	input  logic                 min_first,
	output logic                 above
);

	assign above = min_first ? (a < b) : (a > b);

endmodule

>>> bench/tb_binary_heap_priority_queue_top.sv
`timescale 1ns / 1ps

module tb_binary_heap_priority_queue_top;
	import bhpq_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int END_WAIT    = 60;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	bhpq_in_t  in_data   = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	bhpq_out_t out_data;
	logic      cfg_we    = 1'b0;
	logic      cfg_wdata = 1'b0;

	// Mirror of the heap contents and the order bit.
	logic [KEY_BITS-1:0] model_keys [CAPACITY];
	int                  model_count = 0;
	bit                  model_min_first = 1'b0;

	bhpq_out_t pending_results[$];
	int        error_count  = 0;
	int        rx_hold      = 0;
	int        quiet_cycles = 0;
	bit        no_idle      = 1'b0;

	binary_heap_priority_queue_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic bit outranks(logic [KEY_BITS-1:0] a, logic [KEY_BITS-1:0] b);
		return model_min_first ? (a < b) : (a > b);
	endfunction

	function automatic bhpq_out_t apply_queue_op(bhpq_in_t item);
		bhpq_out_t           r;
		int                  pos;
		int                  parent;
		int                  pick;
		logic [KEY_BITS-1:0] t;
		r = '0;
		r.status = STAT_OK;
		if (item.op == OP_PUSH) begin
			if (model_count >= CAPACITY) begin
				r.status = STAT_FULL;
			end else begin
				pos = model_count;
				model_keys[pos] = item.key;
				model_count++;
				while (pos > 0) begin
					parent = (pos - 1) / 2;
					if (!outranks(model_keys[pos], model_keys[parent]))
						break;
					t = model_keys[pos];
					model_keys[pos] = model_keys[parent];
					model_keys[parent] = t;
					pos = parent;
				end
			end
		end else if (model_count == 0) begin
			r.status = STAT_EMPTY;
		end else begin
			r.popped_key = model_keys[0];
			model_count--;
			model_keys[0] = model_keys[model_count];
			pos = 0;
			while (2 * pos + 1 < model_count) begin
				pick = 2 * pos + 1;
				// The right child wins only when it is strictly better.
				if (pick + 1 < model_count && outranks(model_keys[pick + 1], model_keys[pick]))
					pick = pick + 1;
				if (!outranks(model_keys[pick], model_keys[pos]))
					break;
				t = model_keys[pos];
				model_keys[pos] = model_keys[pick];
				model_keys[pick] = t;
				pos = pick;
			end
		end
		r.top_valid = (model_count > 0);
		r.top_key   = (model_count > 0) ? model_keys[0] : '0;
		r.count     = model_count[COUNT_BITS-1:0];
		return r;
	endfunction

	function automatic int draw_idle();
		return no_idle ? 0 : $urandom_range(0, 12);
	endfunction

	function automatic logic [KEY_BITS-1:0] rand_key();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 15);
			1: return $urandom_range(0, 1) ? '1 : '0;
			2: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
			default: return $urandom();
		endcase
	endfunction

	task automatic check_field(string name, logic [KEY_BITS-1:0] exp_val,
			logic [KEY_BITS-1:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, act_val);
			error_count++;
		end
	endtask

	// Result side: check each transfer, then draw the stall for the next one.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing pending: %p", out_data);
				error_count++;
			end else begin
				check_field("status", pending_results[0].status, out_data.status);
				check_field("popped_key", pending_results[0].popped_key, out_data.popped_key);
				check_field("top_key", pending_results[0].top_key, out_data.top_key);
				check_field("top_valid", pending_results[0].top_valid, out_data.top_valid);
				check_field("count", pending_results[0].count, out_data.count);
				void'(pending_results.pop_front());
			end
			rx_hold = draw_idle();
			out_stall <= (rx_hold != 0);
		end else if (out_valid && out_stall) begin
			rx_hold--;
			out_stall <= (rx_hold > 0);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic send_item(op_t op, logic [KEY_BITS-1:0] key);
		bhpq_in_t item;
		int       gap;
		item.op  = op;
		item.key = key;
		gap = draw_idle();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(apply_queue_op(item));
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_order(bit smallest_first);
		wait_for_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= smallest_first;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_min_first = smallest_first;
	endtask

	task automatic send_random(int push_pct);
		if ($urandom_range(1, 100) <= push_pct)
			send_item(OP_PUSH, rand_key());
		else
			send_item(OP_POP, '0);
	endtask

	task automatic test_directed_max_first();
		write_order(1'b0);
		send_item(OP_POP, 32'h1234_5678);
		send_item(OP_PUSH, 32'h0000_0000);
		send_item(OP_PUSH, 32'hFFFF_FFFF);
		send_item(OP_PUSH, 32'h8000_0000);
		send_item(OP_PUSH, 32'hFFFF_FFFF);
		send_item(OP_PUSH, 32'h5555_5555);
		send_item(OP_PUSH, 32'hAAAA_AAAA);
		repeat (7) send_item(OP_POP, 32'hFFFF_FFFF);
	endtask

	task automatic test_directed_min_first();
		write_order(1'b1);
		send_item(OP_PUSH, 32'd5);
		send_item(OP_PUSH, 32'd5);
		send_item(OP_PUSH, 32'd3);
		send_item(OP_PUSH, 32'hFFFF_FFFF);
		send_item(OP_PUSH, 32'd0);
		send_item(OP_POP, '0);
		// Entries stay where they are; only later sifts use the new order.
		write_order(1'b0);
		repeat (4) send_item(OP_POP, '0);
	endtask

	task automatic test_random_mix();
		for (int chunk = 0; chunk < 3; chunk++) begin
			write_order(chunk[0]);
			no_idle = (chunk == 1);
			repeat (100) send_random(60);
		end
		no_idle = 1'b0;
	endtask

	task automatic test_fill_to_capacity();
		write_order($urandom_range(0, 1));
		while (model_count < CAPACITY) send_random(95);
		repeat (6) send_item(OP_PUSH, rand_key());
		send_item(OP_POP, '0);
		send_item(OP_PUSH, rand_key());
		send_item(OP_PUSH, rand_key());
	endtask

	task automatic test_drain_switched_order();
		write_order(!model_min_first);
		repeat (250) send_random(30);
		write_order(!model_min_first);
		no_idle = 1'b1;
		repeat (80) send_random(30);
		no_idle = 1'b0;
		repeat (220) send_random(30);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_max_first();
		test_directed_min_first();
		test_random_mix();
		test_fill_to_capacity();
		test_drain_switched_order();
		wait_for_results();
		repeat (END_WAIT) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
